>>> rtl/core/qtbn_pkg.sv
// ----------------------------------------------------------------------------
// qtbn_pkg
// widths, lane control type and rounding helpers for the qtangent frame core
// ----------------------------------------------------------------------------
`default_nettype none

package qtbn_pkg;

    localparam int QW     = 16;              // quaternion word
    localparam int PW     = 2 * QW;          // 16x16 product
    localparam int RW     = PW + 1;          // half-scaled row value
    localparam int NW     = 64;              // row x row product
    localparam int DW     = NW + 2;          // normal difference
    localparam int OW     = 19;              // q3.15 result
    localparam int ROW_SH = 14;
    localparam int NRM_SH = 43;
    localparam int RQW    = RW + 1 - ROW_SH;
    localparam int SQW    = DW + 1 - NRM_SH;

    localparam logic signed [RW-1:0]  ROW_ONE  = {{(RW-30){1'b0}}, 1'b1, {29{1'b0}}};
    localparam logic signed [RW:0]    ROW_HALF =
        {{(RW-ROW_SH+1){1'b0}}, 1'b1, {(ROW_SH-1){1'b0}}};
    localparam logic signed [DW:0]    NRM_HALF =
        {{(DW-NRM_SH+1){1'b0}}, 1'b1, {(NRM_SH-1){1'b0}}};
    localparam logic signed [SQW-1:0] SAT_HI   =
        {{(SQW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [SQW-1:0] SAT_LO   =
        {{(SQW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    typedef logic signed [QW-1:0] t_quat;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [RW-1:0] t_row;
    typedef logic signed [OW-1:0] t_out;

    typedef struct packed {
        logic en_mul;
        logic en_sub;
        logic en_out;
        logic flip;
    } t_lane_ctl;

    function automatic t_row ext_prod(input t_prod p);
        return {p[PW-1], p};
    endfunction

    function automatic t_out sat_out(input logic signed [SQW-1:0] v);
        logic signed [SQW-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[OW-1:0];
    endfunction

    function automatic t_out round_row(input t_row v);
        logic signed [RW:0]    s;
        logic signed [RQW-1:0] q;
        s = $signed({v[RW-1], v}) + ROW_HALF;
        q = s[RW:ROW_SH];
        return sat_out({{(SQW-RQW){q[RQW-1]}}, q});
    endfunction

    function automatic t_out round_nrm(input logic signed [DW-1:0] v);
        logic signed [DW:0] s;
        s = $signed({v[DW-1], v}) + NRM_HALF;
        return sat_out(s[DW:NRM_SH]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/qtangent_to_tbn_frame_core.sv
// ----------------------------------------------------------------------------
// qtangent_to_tbn_frame_core
// packed qtangent quaternion to tangent, binormal and normal in q3.15
// ----------------------------------------------------------------------------
// Accepts one word per cycle while o_ready is high; its frame passes through a
// five-stage pipeline: 16x16 products, row sums, 33x33 row products for the
// cross product, the signed difference, and rounding with saturation into the
// output register. With i_ready held high the throughput is one word per
// clock; a stall at the output fills empty stages first and only then drops
// o_ready, so no word is lost or repeated.
`default_nettype none

module qtangent_to_tbn_frame_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire qtbn_pkg::t_quat i_quat_x,
    input  wire qtbn_pkg::t_quat i_quat_y,
    input  wire qtbn_pkg::t_quat i_quat_z,
    input  wire qtbn_pkg::t_quat i_quat_w,
    output logic                o_valid,
    input  wire logic           i_ready,
    output qtbn_pkg::t_out      o_tangent_x,
    output qtbn_pkg::t_out      o_tangent_y,
    output qtbn_pkg::t_out      o_tangent_z,
    output qtbn_pkg::t_out      o_binormal_x,
    output qtbn_pkg::t_out      o_binormal_y,
    output qtbn_pkg::t_out      o_binormal_z,
    output qtbn_pkg::t_out      o_normal_x,
    output qtbn_pkg::t_out      o_normal_y,
    output qtbn_pkg::t_out      o_normal_z
);
    import qtbn_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: products
    t_prod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic  r_flip1;
    // stage 2: half-scaled rows
    t_row  r_tx, r_ty, r_tz, r_bx, r_by, r_bz;
    logic  r_flip2;
    // stages 3 to 5: rounded rows
    t_out  r_t3 [3];
    t_out  r_b3 [3];
    t_out  r_t4 [3];
    t_out  r_b4 [3];
    t_out  r_t5 [3];
    t_out  r_b5 [3];
    logic  r_flip3;

    t_lane_ctl lane_ctl;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_xx    <= i_quat_x * i_quat_x;
            r_yy    <= i_quat_y * i_quat_y;
            r_zz    <= i_quat_z * i_quat_z;
            r_xy    <= i_quat_x * i_quat_y;
            r_xz    <= i_quat_x * i_quat_z;
            r_yz    <= i_quat_y * i_quat_z;
            r_wx    <= i_quat_w * i_quat_x;
            r_wy    <= i_quat_w * i_quat_y;
            r_wz    <= i_quat_w * i_quat_z;
            r_flip1 <= i_quat_w[QW-1];
        end
        if (rdy2) begin
            r_tx    <= ROW_ONE - (ext_prod(r_yy) + ext_prod(r_zz));
            r_ty    <= ext_prod(r_xy) + ext_prod(r_wz);
            r_tz    <= ext_prod(r_xz) - ext_prod(r_wy);
            r_bx    <= ext_prod(r_xy) - ext_prod(r_wz);
            r_by    <= ROW_ONE - (ext_prod(r_xx) + ext_prod(r_zz));
            r_bz    <= ext_prod(r_yz) + ext_prod(r_wx);
            r_flip2 <= r_flip1;
        end
        if (rdy3) begin
            r_t3[0] <= round_row(r_tx);
            r_t3[1] <= round_row(r_ty);
            r_t3[2] <= round_row(r_tz);
            r_b3[0] <= round_row(r_bx);
            r_b3[1] <= round_row(r_by);
            r_b3[2] <= round_row(r_bz);
            r_flip3 <= r_flip2;
        end
        if (rdy4) begin
            r_t4 <= r_t3;
            r_b4 <= r_b3;
        end
        if (rdy5) begin
            r_t5 <= r_t4;
            r_b5 <= r_b4;
        end
    end

    always_comb begin
        lane_ctl.en_mul = rdy3;
        lane_ctl.en_sub = rdy4;
        lane_ctl.en_out = rdy5;
        lane_ctl.flip   = r_flip3;
    end

    qtbn_normal_lane u_nrm_x (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_a   (r_ty),
        .i_b   (r_bz),
        .i_c   (r_tz),
        .i_d   (r_by),
        .o_nrm (o_normal_x)
    );

    qtbn_normal_lane u_nrm_y (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_a   (r_tz),
        .i_b   (r_bx),
        .i_c   (r_tx),
        .i_d   (r_bz),
        .o_nrm (o_normal_y)
    );

    qtbn_normal_lane u_nrm_z (
        .i_clk (i_clk),
        .i_ctl (lane_ctl),
        .i_a   (r_tx),
        .i_b   (r_by),
        .i_c   (r_ty),
        .i_d   (r_bx),
        .o_nrm (o_normal_z)
    );

    assign o_valid      = r_v5;
    assign o_tangent_x  = r_t5[0];
    assign o_tangent_y  = r_t5[1];
    assign o_tangent_z  = r_t5[2];
    assign o_binormal_x = r_b5[0];
    assign o_binormal_y = r_b5[1];
    assign o_binormal_z = r_b5[2];

endmodule

`default_nettype wire

>>> rtl/core/qtbn_normal_lane.sv
// ----------------------------------------------------------------------------
// qtbn_normal_lane
// one normal component: a*b - c*d, sign flip, round and saturate, three stages
// ----------------------------------------------------------------------------
`default_nettype none

module qtbn_normal_lane (
    input  wire logic                i_clk,
    input  wire qtbn_pkg::t_lane_ctl i_ctl,
    input  wire qtbn_pkg::t_row      i_a,
    input  wire qtbn_pkg::t_row      i_b,
    input  wire qtbn_pkg::t_row      i_c,
    input  wire qtbn_pkg::t_row      i_d,
    output qtbn_pkg::t_out           o_nrm
);
    import qtbn_pkg::*;

    logic signed [2*RW-1:0] n_p;
    logic signed [2*RW-1:0] n_q;
    logic signed [NW-1:0]   r_p;
    logic signed [NW-1:0]   r_q;
    logic signed [DW-1:0]   n_d;
    logic signed [DW-1:0]   r_d;
    t_out                   r_nrm;

    assign n_p = i_a * i_b;
    assign n_q = i_c * i_d;

    always_comb begin
        if (i_ctl.flip) begin
            n_d = $signed({{(DW-NW){r_q[NW-1]}}, r_q}) - $signed({{(DW-NW){r_p[NW-1]}}, r_p});
        end else begin
            n_d = $signed({{(DW-NW){r_p[NW-1]}}, r_p}) - $signed({{(DW-NW){r_q[NW-1]}}, r_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_p <= n_p[NW-1:0];
            r_q <= n_q[NW-1:0];
        end
        if (i_ctl.en_sub) begin
            r_d <= n_d;
        end
        if (i_ctl.en_out) begin
            r_nrm <= round_nrm(r_d);
        end
    end

    assign o_nrm = r_nrm;

endmodule

`default_nettype wire

>>> rtl/core/qtbn_checker.sv
// ----------------------------------------------------------------------------
// qtbn_checker
// port-level checks for the qtangent frame core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module qtbn_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_valid,
    input wire logic            o_ready,
    input wire logic            o_valid,
    input wire logic            i_ready,
    input wire qtbn_pkg::t_out  o_tangent_x,
    input wire qtbn_pkg::t_out  o_normal_x
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tangent_x) && $stable(o_normal_x))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // a draining output never blocks the input
    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output drains");

    // after reset release, no word leaves before the first input can pass through the pipeline
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid [*5])
        else $error("output word appeared too early");

endmodule

bind qtangent_to_tbn_frame_core qtbn_checker u_qtbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_tangent_x (o_tangent_x),
    .o_normal_x  (o_normal_x)
);

`default_nettype wire
